@@ hdl/pfrd_pkg.sv @@
// shared types and constants for the page frame store rectangle engine
// no dependencies; imported by every module of the block
package pfrd_pkg;

    // payload widths on the stream ports
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;

    // widest column and page indexes over the supported geometry
    localparam int COL_MAX_W  = 8;
    localparam int PAGE_MAX_W = 4;

    // width of x + w and y + h sums
    localparam int COL_SUM_W  = 9;
    localparam int ROW_SUM_W  = 8;

    // command queue between front and engine
    localparam int QUEUE_DEPTH     = 2;
    localparam int OUTSTANDING_MAX = QUEUE_DEPTH + 2;

    // request kinds on the tuser field
    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_DRAW  = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NOP   = 2'd3
    } req_type_t;

    // drawing modes on the fill_mode field
    typedef enum logic [1:0] {
        DRAW_CLEAR   = 2'd0,
        DRAW_SET     = 2'd1,
        DRAW_OUTLINE = 2'd2
    } draw_mode_t;

    // classified operations handed to the engine
    typedef enum logic [1:0] {
        OP_NOP,
        OP_CLEAR,
        OP_DRAW,
        OP_READ
    } cmd_op_t;

    // engine sequencer states
    typedef enum logic [2:0] {
        ENG_SWEEP,
        ENG_IDLE,
        ENG_RUN,
        ENG_FLUSH,
        ENG_READ,
        ENG_DONE
    } eng_state_t;

    // one classified command; a read reuses page_first and x_first as its address
    typedef struct packed {
        cmd_op_t                 op;
        draw_mode_t              mode;
        logic [COL_MAX_W-1:0]    x_first;
        logic [COL_MAX_W-1:0]    x_last;
        logic                    right_on;
        logic [PAGE_MAX_W-1:0]   page_first;
        logic [PAGE_MAX_W-1:0]   page_last;
        logic [2:0]              lo_bit;
        logic [2:0]              hi_bit;
        logic                    bot_on;
    } cmd_t;

endpackage

@@ hdl/pfrd_front.sv @@
// request front end: unpacks a request, clips the rectangle and classifies it
// depends on pfrd_pkg; feeds pfrd_cmd_queue
module pfrd_front
    import pfrd_pkg::*;
#(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
)
(
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic [IN_USER_W-1:0] s_tuser,
    input  logic                 q_full,
    input  logic                 sweeping,
    output logic                 push,
    output cmd_t                 cmd
);

    localparam int ROWS = PAGES * 8;
    localparam logic [COL_SUM_W-1:0] COLS_V  = COL_SUM_W'(COLUMNS);
    localparam logic [ROW_SUM_W-1:0] ROWS_V  = ROW_SUM_W'(ROWS);
    localparam logic [4:0]           PAGES_V = 5'(PAGES);

    logic [6:0]           x0;
    logic [5:0]           y0;
    logic [7:0]           w;
    logic [6:0]           h;
    logic [1:0]           fm;
    logic [2:0]           rp;
    logic [6:0]           rc;
    logic [COL_SUM_W-1:0] xsum;
    logic [COL_SUM_W-1:0] x_end;
    logic [COL_SUM_W-1:0] x_last;
    logic [ROW_SUM_W-1:0] ysum;
    logic [ROW_SUM_W-1:0] y_end;
    logic [ROW_SUM_W-1:0] y_last;
    logic                 right_on;
    logic                 bot_on;
    logic                 empty_rect;
    logic                 read_ok;
    draw_mode_t           mode;

    // field unpack
    assign x0 = s_tdata[6:0];
    assign y0 = s_tdata[12:7];
    assign w  = s_tdata[20:13];
    assign h  = s_tdata[27:21];
    assign fm = s_tdata[29:28];
    assign rp = s_tdata[32:30];
    assign rc = s_tdata[39:33];

    // clip the rectangle to the screen
    assign xsum       = COL_SUM_W'(x0) + COL_SUM_W'(w);
    assign ysum       = ROW_SUM_W'(y0) + ROW_SUM_W'(h);
    assign right_on   = (xsum <= COLS_V);
    assign bot_on     = (ysum <= ROWS_V);
    assign x_end      = right_on ? xsum : COLS_V;
    assign y_end      = bot_on ? ysum : ROWS_V;
    assign x_last     = x_end - COL_SUM_W'(1);
    assign y_last     = y_end - ROW_SUM_W'(1);
    assign empty_rect = (w == 8'd0) || (h == 7'd0) ||
                        (COL_SUM_W'(x0) >= COLS_V) || (ROW_SUM_W'(y0) >= ROWS_V);

    // read address range check
    assign read_ok = (5'(rp) < PAGES_V) && (COL_SUM_W'(rc) < COLS_V);

    // mode decode, any unknown mode draws an outline
    always_comb
    begin
        case (fm)
            DRAW_CLEAR: mode = DRAW_CLEAR;
            DRAW_SET:   mode = DRAW_SET;
            default:    mode = DRAW_OUTLINE;
        endcase
    end

    // command build
    always_comb
    begin
        cmd            = '0;
        cmd.op         = OP_NOP;
        cmd.mode       = mode;
        cmd.x_first    = COL_MAX_W'(x0);
        cmd.x_last     = x_last[COL_MAX_W-1:0];
        cmd.right_on   = right_on;
        cmd.page_first = PAGE_MAX_W'(y0[5:3]);
        cmd.page_last  = y_last[ROW_SUM_W-2 -: PAGE_MAX_W];
        cmd.lo_bit     = y0[2:0];
        cmd.hi_bit     = y_last[2:0];
        cmd.bot_on     = bot_on;
        case (s_tuser)
            REQ_CLEAR: cmd.op = OP_CLEAR;
            REQ_DRAW:  cmd.op = empty_rect ? OP_NOP : OP_DRAW;
            REQ_READ:
            begin
                cmd.op         = read_ok ? OP_READ : OP_NOP;
                cmd.page_first = PAGE_MAX_W'(rp);
                cmd.x_first    = COL_MAX_W'(rc);
            end
            default:   cmd.op = OP_NOP;
        endcase
    end

    // handshake
    assign s_tready = !q_full && !sweeping;
    assign push     = s_tvalid && s_tready;

endmodule

@@ hdl/pfrd_cmd_queue.sv @@
// short command queue between the front end and the drawing engine
// depends on pfrd_pkg for cmd_t and the queue depth
module pfrd_cmd_queue
    import pfrd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t cmd_in,
    input  logic pop,
    output cmd_t cmd_out,
    output logic full,
    output logic empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign cmd_out = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

@@ hdl/pfrd_engine.sv @@
// drawing engine: frame store memory, page/column sequencer and result register
// depends on pfrd_pkg; takes commands from pfrd_cmd_queue
module pfrd_engine
    import pfrd_pkg::*;
#(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  logic                  q_empty,
    output logic                  pop,
    output logic                  sweeping,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int AW    = PW + CW;
    localparam int DEPTH = PAGES * (2 ** CW);
    localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
    localparam logic [PW-1:0] PAGE_LAST = PW'(PAGES - 1);

    logic [7:0]            frame_mem [DEPTH];

    eng_state_t            state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [PW-1:0]         page_reg, page_next;
    logic [CW-1:0]         col_reg, col_next;
    logic                  wb_valid_reg, wb_valid_next;
    logic [AW-1:0]         wb_addr_reg, wb_addr_next;
    logic [7:0]            wb_mask_reg, wb_mask_next;
    logic                  wb_set_reg, wb_set_next;
    logic [7:0]            rd_data_reg;
    logic [7:0]            result_reg, result_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic                  clearing;
    logic [CW-1:0]         col_start, col_end;
    logic [PW-1:0]         page_end;
    logic                  last_col, last_page;
    logic                  on_first, on_last;
    logic [2:0]            lo, hi;
    logic [7:0]            band_mask, row_edges, draw_mask;
    logic                  col_is_side;
    logic [AW-1:0]         cur_addr;
    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    logic [7:0]            mem_wd;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;

    // sweep ranges: whole store when clearing, clipped rectangle when drawing
    assign clearing  = (state_reg == ENG_SWEEP) || (cmd_reg.op == OP_CLEAR);
    assign col_start = clearing ? '0 : cmd_reg.x_first[CW-1:0];
    assign col_end   = clearing ? COL_LAST : cmd_reg.x_last[CW-1:0];
    assign page_end  = clearing ? PAGE_LAST : cmd_reg.page_last[PW-1:0];
    assign last_col  = (col_reg == col_end);
    assign last_page = (page_reg == page_end);
    assign cur_addr  = {page_reg, col_reg};

    // pixel mask of the current byte
    assign on_first    = (page_reg == cmd_reg.page_first[PW-1:0]);
    assign on_last     = (page_reg == cmd_reg.page_last[PW-1:0]);
    assign lo          = on_first ? cmd_reg.lo_bit : 3'd0;
    assign hi          = on_last ? cmd_reg.hi_bit : 3'd7;
    assign col_is_side = (col_reg == cmd_reg.x_first[CW-1:0]) ||
                         (cmd_reg.right_on && (col_reg == cmd_reg.x_last[CW-1:0]));

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            band_mask[i] = (3'(i) >= lo) && (3'(i) <= hi);
        end
        row_edges = '0;
        if (on_first)
        begin
            row_edges = row_edges | (8'd1 << cmd_reg.lo_bit);
        end
        if (cmd_reg.bot_on && on_last)
        begin
            row_edges = row_edges | (8'd1 << cmd_reg.hi_bit);
        end
        draw_mask = ((cmd_reg.mode == DRAW_OUTLINE) && !col_is_side) ? row_edges : band_mask;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ENG_SWEEP:
            begin
                if (last_col && last_page)
                begin
                    state_next = ENG_IDLE;
                end
            end
            ENG_IDLE:
            begin
                if (!q_empty)
                begin
                    case (cmd.op)
                        OP_CLEAR: state_next = ENG_RUN;
                        OP_DRAW:  state_next = ENG_RUN;
                        OP_READ:  state_next = ENG_READ;
                        default:  state_next = ENG_DONE;
                    endcase
                end
            end
            ENG_RUN:
            begin
                if (last_col && last_page)
                begin
                    state_next = clearing ? ENG_DONE : ENG_FLUSH;
                end
            end
            ENG_FLUSH: state_next = ENG_DONE;
            ENG_READ:  state_next = ENG_DONE;
            ENG_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ENG_IDLE;
                end
            end
            default:   state_next = ENG_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        pop            = 1'b0;
        cmd_next       = cmd_reg;
        page_next      = page_reg;
        col_next       = col_reg;
        wb_valid_next  = 1'b0;
        wb_addr_next   = wb_addr_reg;
        wb_mask_next   = wb_mask_reg;
        wb_set_next    = wb_set_reg;
        result_next    = result_reg;
        rd_en          = 1'b0;
        rd_addr        = cur_addr;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        case (state_reg)
            ENG_IDLE:
            begin
                if (!q_empty)
                begin
                    pop         = 1'b1;
                    cmd_next    = cmd;
                    result_next = '0;
                    if (cmd.op == OP_CLEAR)
                    begin
                        page_next = '0;
                        col_next  = '0;
                    end
                    else
                    begin
                        page_next = cmd.page_first[PW-1:0];
                        col_next  = cmd.x_first[CW-1:0];
                    end
                    if (cmd.op == OP_READ)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = {cmd.page_first[PW-1:0], cmd.x_first[CW-1:0]};
                    end
                end
            end
            ENG_SWEEP, ENG_RUN:
            begin
                // draw: read now, merge and write back next cycle
                if (!clearing)
                begin
                    rd_en         = 1'b1;
                    wb_valid_next = 1'b1;
                    wb_addr_next  = cur_addr;
                    wb_mask_next  = draw_mask;
                    wb_set_next   = (cmd_reg.mode != DRAW_CLEAR);
                end
                if (last_col)
                begin
                    col_next = col_start;
                    if (!last_page)
                    begin
                        page_next = page_reg + PW'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end
            ENG_READ:
            begin
                result_next = rd_data_reg;
            end
            ENG_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = result_reg;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // memory write port: pending merge first, else clearing write
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = cur_addr;
        mem_wd = '0;
        if (wb_valid_reg)
        begin
            mem_we = 1'b1;
            mem_wa = wb_addr_reg;
            mem_wd = wb_set_reg ? (rd_data_reg | wb_mask_reg) : (rd_data_reg & ~wb_mask_reg);
        end
        else if (clearing && ((state_reg == ENG_SWEEP) || (state_reg == ENG_RUN)))
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= frame_mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ENG_SWEEP;
            page_reg      <= '0;
            col_reg       <= '0;
            wb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            page_reg      <= page_next;
            col_reg       <= col_next;
            wb_valid_reg  <= wb_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        wb_addr_reg  <= wb_addr_next;
        wb_mask_reg  <= wb_mask_next;
        wb_set_reg   <= wb_set_next;
        result_reg   <= result_next;
        out_data_reg <= out_data_next;
    end

    assign sweeping = (state_reg == ENG_SWEEP);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ hdl/page_framebuffer_rectangle_draw.sv @@
// top level of the page frame store rectangle engine
// depends on pfrd_pkg, pfrd_front, pfrd_cmd_queue and pfrd_engine
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------
//  s_*      | in        | tuser: req_type; tdata: x, y, width, height, mode,
//           |           |        read page, read column
//  m_*      | out       | tdata: read_data, one result per request
//
// a rectangle runs one byte read-modify-write a cycle through the single
// write port of the store; a clear writes zeros over the whole store.
// after reset the store is zeroed by a pass over every byte, during which
// s_tready stays low. a two-deep queue lets requests be accepted while
// the engine works or a result waits on m_tready.
module page_framebuffer_rectangle_draw
    import pfrd_pkg::*;
#(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [6:0] x_pos, [12:7] y_pos, [20:13] rect_width, [27:21] rect_height,
    // [29:28] fill_mode, [32:30] read_page, [39:33] read_column
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] req_type
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] read_data
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    logic sweeping;
    cmd_t front_cmd;
    cmd_t queue_cmd;

    // request classification
    pfrd_front #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .sweeping (sweeping),
        .push     (push),
        .cmd      (front_cmd)
    );

    // command queue
    pfrd_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (front_cmd),
        .pop     (pop),
        .cmd_out (queue_cmd),
        .full    (q_full),
        .empty   (q_empty)
    );

    // drawing engine and frame store
    pfrd_engine #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (queue_cmd),
        .q_empty  (q_empty),
        .pop      (pop),
        .sweeping (sweeping),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ hdl/pfrd_checker.sv @@
// port-level checks for the page frame store rectangle engine
// depends on pfrd_pkg; bound to page_framebuffer_rectangle_draw below
module pfrd_checker
    import pfrd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    logic [2:0] pend_reg, pend_next;
    logic       in_acc, out_acc;

    // requests accepted but not yet answered
    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_acc && !out_acc)
        begin
            pend_next = pend_reg + 3'd1;
        end
        else if (out_acc && !in_acc)
        begin
            pend_next = pend_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its data
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // no result without a request behind it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pend_reg != 3'd0)
        else $error("result without an outstanding request");

    // queue, engine and output register bound the requests in flight
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'(OUTSTANDING_MAX))
        else $error("too many requests in flight");

endmodule

bind page_framebuffer_rectangle_draw pfrd_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ bench/frame_mirror_pkg.sv @@
// scoreboard for the page frame store rectangle engine bench: a byte mirror of the store
// depends on pfrd_pkg; used by page_framebuffer_rectangle_draw_test
package frame_mirror_pkg;
    import pfrd_pkg::*;

    // default geometry of the block under test
    localparam int COLUMNS     = 128;
    localparam int PAGES       = 8;
    localparam int SCREEN_ROWS = PAGES * 8;
    localparam int STORE_BYTES = PAGES * COLUMNS;

    // mode code with no name in the block; drawn as an outline
    localparam logic [1:0] DRAW_SPARE = 2'd3;

    // request fields as packed on s_tdata, x_pos in the lowest bits
    typedef struct packed {
        logic [6:0] read_column;
        logic [2:0] read_page;
        logic [1:0] fill_mode;
        logic [6:0] rect_height;
        logic [7:0] rect_width;
        logic [5:0] y_pos;
        logic [6:0] x_pos;
    } rect_req_t;

    class frame_mirror;
        logic [7:0]  pixel_bytes [STORE_BYTES];
        logic [7:0]  bytes_due [$];
        int unsigned mismatches;

        function new();
            wipe();
            mismatches = 0;
        endfunction

        function void wipe();
            foreach (pixel_bytes[i])
                pixel_bytes[i] = '0;
        endfunction

        function int unsigned pending();
            return bytes_due.size();
        endfunction

        // update the mirror for one accepted request and queue its result byte
        function void apply_request(logic [1:0] kind, rect_req_t r);
            int unsigned dy, dx, row, col, w, h;
            logic [7:0]  read_val;
            logic        paint, lit;
            read_val = '0;
            w = r.rect_width;
            h = r.rect_height;
            case (kind)
                REQ_CLEAR: wipe();
                REQ_DRAW:
                begin
                    // walk the rectangle row by row; stop at the screen edges
                    for (dy = 0; dy < h; dy++)
                    begin
                        row = r.y_pos + dy;
                        if (row >= SCREEN_ROWS)
                            break;
                        for (dx = 0; dx < w; dx++)
                        begin
                            col = r.x_pos + dx;
                            if (col >= COLUMNS)
                                break;
                            paint = 1'b1;
                            lit   = 1'b1;
                            if (r.fill_mode == DRAW_CLEAR)
                                lit = 1'b0;
                            else if (r.fill_mode != DRAW_SET)
                                paint = (dy == 0 || dy == h - 1 || dx == 0 || dx == w - 1);
                            if (paint)
                                pixel_bytes[(row >> 3) * COLUMNS + col][row & 7] = lit;
                        end
                    end
                end
                REQ_READ: read_val = pixel_bytes[r.read_page * COLUMNS + r.read_column];
                default: ;
            endcase
            bytes_due.push_back(read_val);
        endfunction

        // compare one result byte with the oldest one due
        function void check_read_data(logic [7:0] got);
            logic [7:0] want;
            if (bytes_due.size() == 0)
            begin
                $error("read_data: result with no request waiting, got %02h", got);
                mismatches++;
            end
            else
            begin
                want = bytes_due.pop_front();
                if (got !== want)
                begin
                    $error("read_data: expected %02h, got %02h", want, got);
                    mismatches++;
                end
            end
        endfunction
    endclass

endpackage

@@ bench/page_framebuffer_rectangle_draw_test.sv @@
// stream-level bench for page_framebuffer_rectangle_draw: directed and random requests,
// every result byte checked against a mirror of the frame store
// depends on pfrd_pkg, frame_mirror_pkg and the block's rtl
module page_framebuffer_rectangle_draw_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pfrd_pkg::*;
    import frame_mirror_pkg::*;

    localparam int RANDOM_ITEMS  = 850;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int LIMIT_CYCLES  = 5_000_000;

    typedef enum {STALL_NONE, STALL_COIN, STALL_PATTERN} stall_style_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    frame_mirror mirror = new();

    bit          long_hold_due = 1'b0;
    int unsigned burst_left = 0;
    int unsigned recent_x = 0;
    int unsigned recent_y = 0;
    int unsigned cycle_count = 0;

    page_framebuffer_rectangle_draw dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            mirror.check_read_data(m_tdata);
    end

    // receiver: stall style changes from phase to phase, with one long hold on demand
    initial
    begin
        stall_style_t style;
        int unsigned  phase_left;
        logic [15:0]  stall_bits;
        style      = STALL_NONE;
        phase_left = 0;
        stall_bits = '1;
        forever
        begin
            @(posedge clk);
            if (long_hold_due)
            begin
                long_hold_due = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (phase_left == 0)
            begin
                style      = stall_style_t'($urandom_range(0, 2));
                phase_left = $urandom_range(20, 200);
                stall_bits = 16'($urandom);
            end
            phase_left--;
            case (style)
                STALL_NONE: m_tready <= 1'b1;
                STALL_COIN: m_tready <= 1'($urandom_range(0, 1));
                default:
                begin
                    m_tready   <= stall_bits[0];
                    stall_bits = {stall_bits[0], stall_bits[15:1]};
                end
            endcase
        end
    end

    // offer one request until accepted, then note it and apply burst pacing
    task automatic push_request(input logic [1:0] kind, input rect_req_t r);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= r;
        do
            @(posedge clk);
        while (!s_tready);
        mirror.apply_request(kind, r);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 10);
        end
    endtask

    task automatic send_fields(input logic [1:0] kind, input int x, input int y,
                               input int w, input int h, input logic [1:0] mode,
                               input int page, input int col);
        rect_req_t r;
        r.x_pos       = 7'(x);
        r.y_pos       = 6'(y);
        r.rect_width  = 8'(w);
        r.rect_height = 7'(h);
        r.fill_mode   = mode;
        r.read_page   = 3'(page);
        r.read_column = 7'(col);
        push_request(kind, r);
    endtask

    // hold the sender until every result due has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (mirror.pending() != 0);
    endtask

    // random request: mostly reads and small rectangles, a few large or odd ones
    task automatic pick_request(output logic [1:0] kind, output rect_req_t r);
        int unsigned roll, size_roll;
        r    = rect_req_t'(40'({$urandom, $urandom}));
        roll = $urandom_range(0, 99);
        if (roll < 45)
        begin
            kind = REQ_READ;
            // often read back near the last rectangle
            if ($urandom_range(0, 2) == 0)
            begin
                r.read_page   = 3'(recent_y >> 3);
                r.read_column = 7'(recent_x + $urandom_range(0, 15));
            end
        end
        else if (roll < 88)
        begin
            kind      = REQ_DRAW;
            size_roll = $urandom_range(0, 99);
            if (size_roll < 88)
            begin
                r.rect_width  = 8'($urandom_range(0, 16));
                r.rect_height = 7'($urandom_range(0, 20));
            end
            else if (size_roll >= 97)
            begin
                r.x_pos       = 7'($urandom_range(0, 3));
                r.y_pos       = 6'($urandom_range(0, 3));
                r.rect_width  = 8'(COLUMNS);
                r.rect_height = 7'(SCREEN_ROWS);
            end
            r.fill_mode = ($urandom_range(0, 19) == 0) ? DRAW_SPARE : 2'($urandom_range(0, 2));
            recent_x    = r.x_pos;
            recent_y    = r.y_pos;
        end
        else if (roll < 92)
            kind = REQ_CLEAR;
        else
            kind = REQ_NOP;
    endtask

    // main sequence
    initial
    begin
        logic [1:0]  kind;
        rect_req_t   r;
        int unsigned item;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reads of the fresh store at both corners
        send_fields(REQ_READ, 0, 0, 0, 0, DRAW_CLEAR, 0, 0);
        send_fields(REQ_READ, 0, 0, 0, 0, DRAW_CLEAR, 7, 127);
        // full screen fill, then an oversized clear clipped to the last pixel
        send_fields(REQ_DRAW, 0, 0, 128, 64, DRAW_SET, 0, 0);
        send_fields(REQ_READ, 0, 0, 0, 0, DRAW_CLEAR, 0, 0);
        send_fields(REQ_READ, 0, 0, 0, 0, DRAW_CLEAR, 7, 127);
        send_fields(REQ_DRAW, 127, 63, 255, 127, DRAW_CLEAR, 0, 0);
        send_fields(REQ_READ, 0, 0, 0, 0, DRAW_CLEAR, 7, 127);
        send_fields(REQ_READ, 0, 0, 0, 0, DRAW_CLEAR, 7, 126);
        // no-op request with every field at its top
        send_fields(REQ_NOP, 127, 63, 255, 127, DRAW_SPARE, 7, 127);
        send_fields(REQ_CLEAR, 0, 0, 0, 0, DRAW_CLEAR, 0, 0);
        send_fields(REQ_READ, 0, 0, 0, 0, DRAW_CLEAR, 3, 64);
        // outline spanning three pages
        send_fields(REQ_DRAW, 10, 5, 20, 12, DRAW_OUTLINE, 0, 0);
        send_fields(REQ_READ, 0, 0, 0, 0, DRAW_CLEAR, 0, 10);
        send_fields(REQ_READ, 0, 0, 0, 0, DRAW_CLEAR, 0, 15);
        send_fields(REQ_READ, 0, 0, 0, 0, DRAW_CLEAR, 2, 15);
        send_fields(REQ_READ, 0, 0, 0, 0, DRAW_CLEAR, 1, 29);
        // spare mode as outline with right and bottom edges off screen
        send_fields(REQ_DRAW, 100, 60, 40, 10, DRAW_SPARE, 0, 0);
        send_fields(REQ_READ, 0, 0, 0, 0, DRAW_CLEAR, 7, 100);
        send_fields(REQ_READ, 0, 0, 0, 0, DRAW_CLEAR, 7, 127);
        // zero width and zero height draw nothing
        send_fields(REQ_DRAW, 0, 0, 0, 64, DRAW_SET, 0, 0);
        send_fields(REQ_DRAW, 0, 0, 128, 0, DRAW_SET, 0, 0);
        send_fields(REQ_READ, 0, 0, 0, 0, DRAW_CLEAR, 0, 0);
        // one column wide outline down the last column
        send_fields(REQ_DRAW, 127, 0, 1, 64, DRAW_OUTLINE, 0, 0);
        send_fields(REQ_READ, 0, 0, 0, 0, DRAW_CLEAR, 4, 127);
        drain_results();

        // random traffic with a long receiver hold and a mid-run drain
        for (item = 0; item < RANDOM_ITEMS; item++)
        begin
            if (item == 300)
                long_hold_due = 1'b1;
            if (item == 600)
                drain_results();
            pick_request(kind, r);
            push_request(kind, r);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mirror.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
